// ===== design/lfwd_pkg.sv =====
// Shared constants and controller/datapath interface types for the LZSS flag-word decoder.
package lfwd_pkg;

    localparam int HIST_DEPTH = 256;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam logic [4:0] FLAG_BITS = 5'd16;
    localparam logic [3:0] LEN_BIAS  = 4'd2;

    typedef struct packed {
        logic start;
        logic hdr;
        logic flag_lo;
        logic flag_hi;
        logic take_bit;
        logic mlen_clr;
        logic len_shift;
        logic byte_ld;
        logic lit_wr;
        logic rd;
        logic copy_wr;
    } lfwd_cmd_t;

    typedef struct packed {
        logic hdr_last;
        logic cur_bit;
        logic flags_empty;
        logic size_reached;
        logic out_free;
        logic copy_last;
    } lfwd_stat_t;

endpackage

// ===== design/lfwd_ctrl.sv =====
// Sequencer for the decoder: header, flag word reloads, token parsing and copy steps.
module lfwd_ctrl import lfwd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_block_start,
    output logic       s_ready,
    input  lfwd_stat_t stat,
    output lfwd_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_HEADER  = 4'd1;
    localparam logic [3:0] ST_FLAG_LO = 4'd2;
    localparam logic [3:0] ST_FLAG_HI = 4'd3;
    localparam logic [3:0] ST_BYTE    = 4'd4;
    localparam logic [3:0] ST_DONE    = 4'd5;
    localparam logic [3:0] ST_PARSE   = 4'd6;
    localparam logic [3:0] ST_LIT     = 4'd7;
    localparam logic [3:0] ST_COPY_RD = 4'd8;
    localparam logic [3:0] ST_COPY_WR = 4'd9;

    localparam logic [1:0] TK_NONE = 2'd0;
    localparam logic [1:0] TK_LEN  = 2'd1;
    localparam logic [1:0] TK_LIT  = 2'd2;
    localparam logic [1:0] TK_OFF  = 2'd3;

    logic [3:0] state_reg, state_next;
    logic [1:0] tok_reg, tok_next;
    logic [1:0] len_left_reg, len_left_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE) || (state_reg == ST_HEADER) ||
                     (state_reg == ST_FLAG_LO) || (state_reg == ST_FLAG_HI) ||
                     (state_reg == ST_BYTE) || (state_reg == ST_DONE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next    = state_reg;
        tok_next      = tok_reg;
        len_left_next = len_left_reg;
        cmd           = '0;
        if (accept && s_block_start) begin
            cmd.start     = 1'b1;
            state_next    = ST_HEADER;
            tok_next      = TK_NONE;
            len_left_next = 2'd0;
        end else begin
            case (state_reg)
                ST_IDLE, ST_DONE: begin
                end
                ST_HEADER: begin
                    if (accept) begin
                        cmd.hdr = 1'b1;
                        if (stat.hdr_last) begin
                            state_next = ST_FLAG_LO;
                        end
                    end
                end
                ST_FLAG_LO: begin
                    if (accept) begin
                        cmd.flag_lo = 1'b1;
                        state_next  = ST_FLAG_HI;
                    end
                end
                ST_FLAG_HI: begin
                    if (accept) begin
                        cmd.flag_hi = 1'b1;
                        state_next  = ST_PARSE;
                    end
                end
                ST_BYTE: begin
                    if (accept) begin
                        cmd.byte_ld = 1'b1;
                        state_next  = (tok_reg == TK_LIT) ? ST_LIT : ST_COPY_RD;
                    end
                end
                ST_LIT: begin
                    if (stat.out_free) begin
                        cmd.lit_wr = 1'b1;
                        tok_next   = TK_NONE;
                        state_next = ST_PARSE;
                    end
                end
                ST_COPY_RD: begin
                    cmd.rd     = 1'b1;
                    state_next = ST_COPY_WR;
                end
                ST_COPY_WR: begin
                    if (stat.out_free) begin
                        cmd.copy_wr = 1'b1;
                        if (stat.copy_last) begin
                            tok_next   = TK_NONE;
                            state_next = ST_PARSE;
                        end else begin
                            state_next = ST_COPY_RD;
                        end
                    end
                end
                ST_PARSE: begin
                    // A flag word that just ran dry is reloaded before the token goes on.
                    case (tok_reg)
                        TK_NONE: begin
                            if (stat.size_reached) begin
                                state_next = ST_DONE;
                            end else if (stat.flags_empty) begin
                                state_next = ST_FLAG_LO;
                            end else begin
                                cmd.take_bit = 1'b1;
                                if (stat.cur_bit) begin
                                    cmd.mlen_clr  = 1'b1;
                                    tok_next      = TK_LEN;
                                    len_left_next = 2'd3;
                                end else begin
                                    tok_next = TK_LIT;
                                end
                            end
                        end
                        TK_LIT: begin
                            state_next = stat.flags_empty ? ST_FLAG_LO : ST_BYTE;
                        end
                        TK_LEN: begin
                            if (stat.flags_empty) begin
                                state_next = ST_FLAG_LO;
                            end else if (len_left_reg == 2'd0) begin
                                tok_next   = TK_OFF;
                                state_next = ST_BYTE;
                            end else begin
                                cmd.take_bit  = 1'b1;
                                cmd.len_shift = 1'b1;
                                len_left_next = len_left_reg - 2'd1;
                            end
                        end
                        default: begin
                            state_next = ST_BYTE;
                        end
                    endcase
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tok_reg      <= TK_NONE;
            len_left_reg <= 2'd0;
        end else begin
            state_reg    <= state_next;
            tok_reg      <= tok_next;
            len_left_reg <= len_left_next;
        end
    end

    a_take_needs_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_bit |-> !stat.flags_empty)
        else $error("flag bit taken from an empty flag word");

    a_byte_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BYTE) |-> (tok_reg == TK_LIT || tok_reg == TK_OFF))
        else $error("waiting for a token byte without a literal or offset pending");

    a_done_sized: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> stat.size_reached)
        else $error("block marked done before the declared size was produced");

endmodule

// ===== design/lfwd_dpath.sv =====
// Datapath: history memory, flag word, header size, counters and the output register.
module lfwd_dpath import lfwd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  lfwd_cmd_t   cmd,
    input  logic [7:0]  s_in_byte,
    input  logic        m_ready,
    output lfwd_stat_t  stat,
    output logic        m_valid,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    output logic        m_block_done
);

    logic [7:0]            hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] hist_valid_reg, hist_valid_next;

    logic [HIST_AW-1:0] pos_reg, pos_next;
    logic [15:0]        flag_word_reg, flag_word_next;
    logic [4:0]         flags_left_reg, flags_left_next;
    logic [2:0]         hdr_idx_reg, hdr_idx_next;
    logic [31:0]        target_reg, target_next;
    logic [31:0]        count_reg, count_next;
    logic [2:0]         mlen_reg, mlen_next;
    logic [3:0]         copy_cnt_reg, copy_cnt_next;
    logic [7:0]         byte_reg;
    logic [7:0]         rd_data_reg;
    logic               rd_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;
    logic               out_done_reg;
    logic               out_valid_reg, out_valid_next;

    logic               emit;
    logic [7:0]         emit_byte;
    logic [HIST_AW-1:0] rd_addr;
    logic [31:0]        count_inc;

    assign emit      = cmd.lit_wr || cmd.copy_wr;
    // Entries not written since the block start read as zero.
    assign emit_byte = cmd.lit_wr ? byte_reg : (rd_valid_reg ? rd_data_reg : 8'h00);
    assign rd_addr   = pos_reg + byte_reg[HIST_AW-1:0];
    assign count_inc = (count_reg == 32'hFFFF_FFFF) ? count_reg : count_reg + 32'd1;

    assign stat.hdr_last     = (hdr_idx_reg == 3'd7);
    assign stat.cur_bit      = flag_word_reg[15];
    assign stat.flags_empty  = (flags_left_reg == 5'd0);
    assign stat.size_reached = (count_reg >= target_reg);
    assign stat.out_free     = !out_valid_reg || m_ready;
    assign stat.copy_last    = (copy_cnt_reg == 4'd1);

    always_comb begin
        hist_valid_next = hist_valid_reg;
        pos_next        = pos_reg;
        flag_word_next  = flag_word_reg;
        flags_left_next = flags_left_reg;
        hdr_idx_next    = hdr_idx_reg;
        target_next     = target_reg;
        count_next      = count_reg;
        mlen_next       = mlen_reg;
        copy_cnt_next   = copy_cnt_reg;
        if (cmd.start) begin
            // The start item is header byte zero, which carries no size bits.
            hist_valid_next = '0;
            pos_next        = '0;
            flag_word_next  = 16'h0000;
            flags_left_next = 5'd0;
            hdr_idx_next    = 3'd1;
            target_next     = 32'd0;
            count_next      = 32'd0;
            mlen_next       = 3'd0;
        end else begin
            if (cmd.hdr) begin
                hdr_idx_next = hdr_idx_reg + 3'd1;
                case (hdr_idx_reg)
                    3'd4:    target_next[7:0]   = s_in_byte;
                    3'd5:    target_next[15:8]  = s_in_byte;
                    3'd6:    target_next[23:16] = s_in_byte;
                    3'd7:    target_next[31:24] = s_in_byte;
                    default: begin
                    end
                endcase
            end
            if (cmd.flag_lo) begin
                flag_word_next = {8'h00, s_in_byte};
            end
            if (cmd.flag_hi) begin
                flag_word_next  = {s_in_byte, flag_word_reg[7:0]};
                flags_left_next = FLAG_BITS;
            end
            if (cmd.take_bit) begin
                flag_word_next  = {flag_word_reg[14:0], 1'b0};
                flags_left_next = flags_left_reg - 5'd1;
            end
            if (cmd.mlen_clr) begin
                mlen_next = 3'd0;
            end else if (cmd.len_shift) begin
                mlen_next = {mlen_reg[1:0], flag_word_reg[15]};
            end
            if (cmd.byte_ld) begin
                copy_cnt_next = {1'b0, mlen_reg} + LEN_BIAS;
            end
            if (cmd.copy_wr) begin
                copy_cnt_next = copy_cnt_reg - 4'd1;
            end
            if (emit) begin
                hist_valid_next[pos_reg] = 1'b1;
                pos_next                 = pos_reg + 1'b1;
                count_next               = count_inc;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_valid_reg <= '0;
            pos_reg        <= '0;
            flag_word_reg  <= 16'h0000;
            flags_left_reg <= 5'd0;
            hdr_idx_reg    <= 3'd0;
            target_reg     <= 32'd0;
            count_reg      <= 32'd0;
            mlen_reg       <= 3'd0;
            copy_cnt_reg   <= 4'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            hist_valid_reg <= hist_valid_next;
            pos_reg        <= pos_next;
            flag_word_reg  <= flag_word_next;
            flags_left_reg <= flags_left_next;
            hdr_idx_reg    <= hdr_idx_next;
            target_reg     <= target_next;
            count_reg      <= count_next;
            mlen_reg       <= mlen_next;
            copy_cnt_reg   <= copy_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.byte_ld) begin
            byte_reg <= s_in_byte;
        end
        if (emit) begin
            out_byte_reg <= emit_byte;
            out_last_reg <= cmd.lit_wr || (copy_cnt_reg == 4'd1);
            out_done_reg <= (count_inc >= target_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            hist_mem[pos_reg] <= emit_byte;
        end
        if (cmd.rd) begin
            rd_data_reg  <= hist_mem[rd_addr];
            rd_valid_reg <= hist_valid_reg[rd_addr];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_run_last   = out_last_reg;
    assign m_block_done = out_done_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!out_valid_reg || m_ready))
        else $error("output item overwritten before it was taken");

    a_flags_range: assert property (@(posedge aclk) disable iff (!aresetn)
        flags_left_reg <= FLAG_BITS)
        else $error("flag bit count beyond one flag word");

    a_copy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd |-> (copy_cnt_reg != 4'd0))
        else $error("history read issued with no copy bytes left");

endmodule

// ===== design/lzss_flag_word_decoder_top.sv =====
// Top level of the LZSS flag-word decoder with a 256-byte history window.
//
//  channel   direction  ports                               item
//  s_        in         s_valid s_ready s_in_byte           one compressed byte
//                       s_block_start
//  m_        out        m_valid m_ready m_out_byte          one decoded byte
//                       m_run_last m_block_done
//
// Header and flag word bytes are each taken directly in their own wait state. After the high
// flag byte or a token byte, the sequencer consumes the flag bits of the next token one at a
// time in its parse state, reloading the flag word whenever it runs dry, before it waits for
// the next byte. A literal is written straight from the token byte; each output byte of a match
// goes through a registered history read and then a write back.
// Reset and block start clear all history valid bits at once; there is no clearing pass.
// A stalled output register holds the sequencer in its write step until the item is taken.
module lzss_flag_word_decoder_top import lfwd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_block_start,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_block_done
);

    lfwd_cmd_t  cmd;
    lfwd_stat_t stat;

    lfwd_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_block_start (s_block_start),
        .s_ready       (s_ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    lfwd_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_in_byte    (s_in_byte),
        .m_ready      (m_ready),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_block_done (m_block_done)
    );

endmodule

// ===== bench/lzss_flag_word_decoder_top_test.sv =====
// Self-checking testbench for the LZSS flag-word decoder top level.
`timescale 1ns / 100ps

module lzss_flag_word_decoder_top_test import lfwd_pkg::*;;

    localparam int STREAM_ITEMS = 470;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_FLAG_LO, PH_FLAG_HI, PH_BYTE, PH_DONE
    } dec_phase_t;

    typedef enum logic [1:0] {TOK_NONE, TOK_LEN, TOK_LIT, TOK_OFF} token_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } stream_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } decoded_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte     = '0;
    logic       s_block_start = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_run_last;
    logic       m_block_done;

    lzss_flag_word_decoder_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_block_start (s_block_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_block_done  (m_block_done)
    );

    initial forever #5 aclk = ~aclk;

    // Decoder prediction state.
    logic [7:0]  hist_mem [HIST_DEPTH];
    logic [7:0]  wr_ptr;
    logic [15:0] flags;
    logic [4:0]  flags_left;
    dec_phase_t  dec_phase;
    logic [2:0]  hdr_idx;
    logic [31:0] size_goal;
    logic [31:0] out_count;
    logic [3:0]  copy_len;
    token_t      tok;
    int          len_bits_left;

    decoded_t     expected_q [$];
    stream_byte_t pending [$];
    int           errors = 0;

    // Stream generation state.
    logic [7:0]  blk_q [$];
    logic [15:0] gen_flags;
    int          gen_left;
    int          fed_items = 0;

    int send_wait  = 0;
    int recv_wait  = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;
    int quiet      = 0;

    function automatic void clear_decoder();
        for (int i = 0; i < HIST_DEPTH; i++) hist_mem[i] = '0;
        wr_ptr        = '0;
        flags         = '0;
        flags_left    = '0;
        dec_phase     = PH_IDLE;
        hdr_idx       = '0;
        size_goal     = '0;
        out_count     = '0;
        copy_len      = '0;
        tok           = TOK_NONE;
        len_bits_left = 0;
    endfunction

    function automatic logic pull_flag_bit();
        logic bit_v;
        bit_v = flags[15];
        flags = flags << 1;
        if (flags_left != 0) flags_left--;
        return bit_v;
    endfunction

    function automatic void emit_byte(input logic [7:0] v);
        decoded_t d;
        hist_mem[wr_ptr] = v;
        wr_ptr++;
        if (out_count != '1) out_count++;
        d.data = v;
        d.last = 1'b0;
        d.done = (out_count >= size_goal);
        expected_q.push_back(d);
    endfunction

    // Walks flag bits until a stream byte is needed or the declared size is reached.
    function automatic void advance_tokens();
        logic parked;
        parked = 1'b0;
        while (!parked) begin
            case (tok)
                TOK_NONE: begin
                    if (out_count >= size_goal) begin
                        dec_phase = PH_DONE;
                        parked = 1'b1;
                    end else if (flags_left == 0) begin
                        dec_phase = PH_FLAG_LO;
                        parked = 1'b1;
                    end else begin
                        if (pull_flag_bit()) begin
                            tok = TOK_LEN;
                            len_bits_left = 3;
                            copy_len = '0;
                        end else begin
                            tok = TOK_LIT;
                        end
                        // The flag word reloads as soon as its last bit is used.
                        if (flags_left == 0) begin
                            dec_phase = PH_FLAG_LO;
                            parked = 1'b1;
                        end
                    end
                end
                TOK_LEN: begin
                    if (len_bits_left == 0) begin
                        tok = TOK_OFF;
                        dec_phase = PH_BYTE;
                        parked = 1'b1;
                    end else if (flags_left == 0) begin
                        dec_phase = PH_FLAG_LO;
                        parked = 1'b1;
                    end else begin
                        copy_len = {copy_len[2:0], pull_flag_bit()};
                        len_bits_left--;
                        if (flags_left == 0) begin
                            dec_phase = PH_FLAG_LO;
                            parked = 1'b1;
                        end
                    end
                end
                default: begin
                    dec_phase = PH_BYTE;
                    parked = 1'b1;
                end
            endcase
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic start);
        int         first;
        int         n;
        logic [7:0] src;
        decoded_t   tail;
        first = expected_q.size();
        if (start) begin
            clear_decoder();
            dec_phase = PH_HEADER;
        end
        case (dec_phase)
            PH_HEADER: begin
                if (hdr_idx >= 4) size_goal |= 32'(b) << (8 * (hdr_idx - 4));
                if (hdr_idx == 7) begin
                    hdr_idx = '0;
                    dec_phase = PH_FLAG_LO;
                end else begin
                    hdr_idx++;
                end
            end
            PH_FLAG_LO: begin
                flags = {8'h00, b};
                dec_phase = PH_FLAG_HI;
            end
            PH_FLAG_HI: begin
                flags[15:8] = b;
                flags_left = FLAG_BITS;
                advance_tokens();
            end
            PH_BYTE: begin
                if (tok == TOK_LIT) begin
                    emit_byte(b);
                end else begin
                    n = int'(copy_len[2:0]) + int'(LEN_BIAS);
                    // The source moves with the write pointer, so a copy may overlap itself.
                    for (int i = 0; i < n; i++) begin
                        src = wr_ptr + b;
                        emit_byte(hist_mem[src]);
                    end
                end
                tok = TOK_NONE;
                advance_tokens();
            end
            default: ;
        endcase
        if (expected_q.size() > first) begin
            tail = expected_q.pop_back();
            tail.last = 1'b1;
            expected_q.push_back(tail);
        end
    endfunction

    function automatic void push_item(input logic [7:0] v, input logic start);
        stream_byte_t it;
        it.data  = v;
        it.start = start;
        pending.push_back(it);
        fed_items++;
    endfunction

    function automatic void new_flag_word();
        case ($urandom_range(0, 5))
            0:       gen_flags = 16'h0000;
            1:       gen_flags = 16'hFFFF;
            default: gen_flags = 16'($urandom);
        endcase
        blk_q.push_back(gen_flags[7:0]);
        blk_q.push_back(gen_flags[15:8]);
        gen_left = 16;
    endfunction

    function automatic logic next_gen_bit();
        logic bit_v;
        bit_v = gen_flags[15];
        gen_flags = gen_flags << 1;
        gen_left--;
        if (gen_left == 0) new_flag_word();
        return bit_v;
    endfunction

    // Builds one well-formed block, adding tokens until size or cap output bytes are reached
    // (the last match may go past cap), and queues its first keep bytes, or all of them when keep is negative.
    function automatic void build_block(input logic [31:0] size, input int cap,
                                        input int keep);
        int         made;
        int         stop_at;
        logic [2:0] len3;
        blk_q.delete();
        repeat (4) blk_q.push_back(8'($urandom));
        for (int i = 0; i < 4; i++) blk_q.push_back(size[8*i +: 8]);
        new_flag_word();
        made = 0;
        while (made < size && made < cap) begin
            if (next_gen_bit()) begin
                len3[2] = next_gen_bit();
                len3[1] = next_gen_bit();
                len3[0] = next_gen_bit();
                if ($urandom_range(0, 1) == 0) blk_q.push_back(8'($urandom_range(240, 255)));
                else blk_q.push_back(8'($urandom));
                made += len3 + 2;
            end else begin
                blk_q.push_back(8'($urandom));
                made++;
            end
        end
        stop_at = (keep < 0 || keep > blk_q.size()) ? blk_q.size() : keep;
        for (int i = 0; i < stop_at; i++) push_item(blk_q[i], i == 0);
    endfunction

    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 39) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic void flag_mismatch(input string what, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    // Sender: one item at a time, each followed by a random pause before the next.
    always @(posedge aclk) begin
        stream_byte_t nxt;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_wait > 0) begin
                s_valid   <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (pending.size() != 0) begin
                nxt = pending.pop_front();
                s_in_byte     <= nxt.data;
                s_block_start <= nxt.start;
                s_valid       <= 1'b1;
                send_wait     <= draw_gap(send_burst);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each output item, then predicts from the input item taken at this edge.
    always @(posedge aclk) begin
        decoded_t want;
        int       pause;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
            clear_decoder();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: output item %02h arrived with nothing expected",
                             $time, m_out_byte);
                end else begin
                    want = expected_q.pop_front();
                    if (m_out_byte !== want.data)
                        flag_mismatch("out_byte", want.data, m_out_byte);
                    if (m_run_last !== want.last)
                        flag_mismatch("run_last", want.last, m_run_last);
                    if (m_block_done !== want.done)
                        flag_mismatch("block_done", want.done, m_block_done);
                end
                pause = draw_gap(recv_burst);
                recv_wait <= pause;
                m_ready   <= (pause == 0);
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                m_ready   <= (recv_wait == 1);
            end else begin
                m_ready <= 1'b1;
            end
            if (s_valid && s_ready) decode_byte(s_in_byte, s_block_start);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet == STALL_LIMIT) begin
            $display("lzss_flag_word_decoder_top verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int          kind;
        int          sz;
        logic [31:0] big;

        // A byte before any block start is ignored.
        push_item(8'hA5, 1'b0);
        // Zero size: header and flag word are read, then the block is done at once.
        push_item(8'h00, 1'b1);
        repeat (7) push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h5A, 1'b0);
        // Size 12, flag word 0x7C00: a literal, a nine-byte overlapping copy at distance
        // one, then a two-byte copy with offset zero that reads the cleared history.
        push_item(8'hFF, 1'b1);
        repeat (3) push_item(8'hFF, 1'b0);
        push_item(8'h0C, 1'b0);
        repeat (3) push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h7C, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b0);

        while (fed_items < STREAM_ITEMS) begin
            kind = $urandom_range(0, 9);
            sz = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 90) : $urandom_range(0, 24);
            if (kind <= 6) begin
                build_block(sz, sz, -1);
                // Trailing bytes after the block is done are ignored.
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) push_item(8'($urandom), 1'b0);
            end else if (kind == 7) begin
                build_block(sz, sz, $urandom_range(1, 30));
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 4)) push_item(8'($urandom), 1'b0);
            end else begin
                // A huge declared size keeps the block open until the next start.
                big = $urandom;
                big[31:24] = 8'($urandom_range(1, 255));
                build_block(big, $urandom_range(4, 40), -1);
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_valid || !aresetn) @(negedge aclk);
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (errors == 0 && expected_q.size() == 0) begin
            $display("lzss_flag_word_decoder_top verification clean");
        end else begin
            $display("lzss_flag_word_decoder_top verification failed");
        end
        $finish;
    end

endmodule
